// File: hdl/euler_angles_to_rotation_matrix_core_assert.svh
// assertion macros for the rotation matrix core
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_CORE_ASSERT_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_CORE_ASSERT_SVH

// checked while out of reset
`define ERM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define ERM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hdl/erm_pkg.sv
package erm_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int SC_DEPTH      = CORDIC_STAGES + 2;
    localparam int PIPE_DEPTH    = SC_DEPTH + 3;
    localparam int ZW            = 48;
    localparam int XW            = 34;
    localparam int TW            = 32;
    localparam int SW            = 33;

    localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032874);
    localparam logic signed [TW-1:0] ONE_Q30  = TW'(64'sd1 <<< 30);

    typedef struct packed {
        logic signed [15:0] bank_angle;
        logic signed [15:0] attitude_angle;
        logic signed [15:0] heading_angle;
    } erm_in_t;

    typedef struct packed {
        logic signed [15:0] row0_col0;
        logic signed [15:0] row0_col1;
        logic signed [15:0] row0_col2;
        logic signed [15:0] row1_col0;
        logic signed [15:0] row1_col1;
        logic signed [15:0] row1_col2;
        logic signed [15:0] row2_col0;
        logic signed [15:0] row2_col1;
        logic signed [15:0] row2_col2;
    } erm_out_t;

    function automatic longint unsigned odd_div(longint unsigned p, int k);
        longint unsigned q;
        unique case (k)
            0:  q = p / 1;
            1:  q = p / 3;
            2:  q = p / 5;
            3:  q = p / 7;
            4:  q = p / 9;
            5:  q = p / 11;
            6:  q = p / 13;
            7:  q = p / 15;
            8:  q = p / 17;
            9:  q = p / 19;
            10: q = p / 21;
            11: q = p / 23;
            12: q = p / 25;
            13: q = p / 27;
            14: q = p / 29;
            15: q = p / 31;
            16: q = p / 33;
            17: q = p / 35;
            18: q = p / 37;
            19: q = p / 39;
            20: q = p / 41;
            default: q = 64'd0;
        endcase
        return q;
    endfunction

    // atan(1/2^sh), or atan(1/3) when three is set, in q.40
    function automatic longint atan_series(int sh, bit three);
        longint unsigned p;
        longint sum;
        p = three ? (64'd1 << 40) / 3 : (64'd1 << 40) >> sh;
        sum = 0;
        for (int k = 0; k < 24; k++) begin
            if (p != 0) begin
                if (k % 2 == 1) begin
                    sum = sum - longint'(odd_div(p, k));
                end else begin
                    sum = sum + longint'(odd_div(p, k));
                end
                p = three ? p / 9 : p >> (2 * sh);
            end
        end
        return sum;
    endfunction

    function automatic longint stage_angle(int i);
        return (i == 0) ? atan_series(1, 1'b0) + atan_series(0, 1'b1) : atan_series(i, 1'b0);
    endfunction

    localparam logic signed [ZW-1:0] PI_Q40   = ZW'(4 * stage_angle(0));
    localparam logic signed [ZW-1:0] HALF_Q40 = ZW'(2 * stage_angle(0));

    function automatic logic signed [TW-1:0] mulq(logic signed [TW-1:0] a,
                                                  logic signed [TW-1:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
        return p[61:30];
    endfunction

    function automatic logic signed [15:0] to_q14(logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        logic signed [SW-17:0] r;
        t = v + SW'(32768);
        r = t[SW-1:16];
        if (r > (SW-16)'(16384)) begin
            return 16'sd16384;
        end else if (r < -(SW-16)'(16384)) begin
            return -16'sd16384;
        end
        return 16'(r);
    endfunction

endpackage

// File: hdl/erm_sincos.sv
module erm_sincos (
    input  logic                              aclk,
    input  logic [erm_pkg::SC_DEPTH-1:0]      en,
    input  logic signed [15:0]                angle,
    output logic signed [erm_pkg::TW-1:0]     sin_q30,
    output logic signed [erm_pkg::TW-1:0]     cos_q30
);
    import erm_pkg::*;

    logic signed [ZW-1:0] z_reg [0:CORDIC_STAGES];
    logic signed [XW-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [XW-1:0] y_reg [0:CORDIC_STAGES];
    logic                 neg_reg [0:CORDIC_STAGES];
    logic signed [TW-1:0] sin_reg, cos_reg;

    logic signed [ZW-1:0] z_raw, z_next;
    logic                 neg_next;
    logic signed [XW-1:0] c_full;

    // fold into [-pi/2, pi/2]
    always_comb begin
        z_raw    = {{(ZW-43){angle[15]}}, angle, 27'd0};
        z_next   = z_raw;
        neg_next = 1'b0;
        if (z_raw > HALF_Q40) begin
            z_next   = PI_Q40 - z_raw;
            neg_next = 1'b1;
        end else if (z_raw < -HALF_Q40) begin
            z_next   = -PI_Q40 - z_raw;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            z_reg[0]   <= z_next;
            x_reg[0]   <= GAIN_Q30;
            y_reg[0]   <= '0;
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ANG = ZW'(stage_angle(i));
        always_ff @(posedge aclk) begin
            if (en[i+1]) begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][ZW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ANG;
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ANG;
                end
            end
        end
    end

    assign c_full = neg_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];

    always_ff @(posedge aclk) begin
        if (en[SC_DEPTH-1]) begin
            if (y_reg[CORDIC_STAGES] > XW'(ONE_Q30)) begin
                sin_reg <= ONE_Q30;
            end else if (y_reg[CORDIC_STAGES] < -XW'(ONE_Q30)) begin
                sin_reg <= -ONE_Q30;
            end else begin
                sin_reg <= TW'(y_reg[CORDIC_STAGES]);
            end
            if (c_full > XW'(ONE_Q30)) begin
                cos_reg <= ONE_Q30;
            end else if (c_full < -XW'(ONE_Q30)) begin
                cos_reg <= -ONE_Q30;
            end else begin
                cos_reg <= TW'(c_full);
            end
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

// File: hdl/erm_matrix.sv
module erm_matrix (
    input  logic                          aclk,
    input  logic [2:0]                    en,
    input  logic signed [erm_pkg::TW-1:0] sb,
    input  logic signed [erm_pkg::TW-1:0] cb,
    input  logic signed [erm_pkg::TW-1:0] sa,
    input  logic signed [erm_pkg::TW-1:0] ca,
    input  logic signed [erm_pkg::TW-1:0] sh,
    input  logic signed [erm_pkg::TW-1:0] ch,
    output erm_pkg::erm_out_t             m_out
);
    import erm_pkg::*;

    logic signed [TW-1:0] sb_reg, cb_reg, sa_reg, sa2_reg;
    logic signed [TW-1:0] chsa_reg, shsa_reg;
    logic signed [TW-1:0] chca_reg, shsb_reg, cacb_reg, casb_reg, shca_reg;
    logic signed [TW-1:0] chsb_reg, chcb_reg, shcb_reg;
    logic signed [TW-1:0] chca2_reg, shsb2_reg, cacb2_reg, casb2_reg, shca2_reg;
    logic signed [TW-1:0] chsb2_reg, chcb2_reg, shcb2_reg;
    logic signed [TW-1:0] chsacb_reg, chsasb_reg, shsacb_reg, shsasb_reg;
    erm_out_t             out_reg;

    // first products
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            sb_reg   <= sb;
            cb_reg   <= cb;
            sa_reg   <= sa;
            chsa_reg <= mulq(ch, sa);
            shsa_reg <= mulq(sh, sa);
            chca_reg <= mulq(ch, ca);
            shsb_reg <= mulq(sh, sb);
            cacb_reg <= mulq(ca, cb);
            casb_reg <= mulq(ca, sb);
            shca_reg <= mulq(sh, ca);
            chsb_reg <= mulq(ch, sb);
            chcb_reg <= mulq(ch, cb);
            shcb_reg <= mulq(sh, cb);
        end
    end

    // triple products
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            chsacb_reg <= mulq(chsa_reg, cb_reg);
            chsasb_reg <= mulq(chsa_reg, sb_reg);
            shsacb_reg <= mulq(shsa_reg, cb_reg);
            shsasb_reg <= mulq(shsa_reg, sb_reg);
            sa2_reg    <= sa_reg;
            chca2_reg  <= chca_reg;
            shsb2_reg  <= shsb_reg;
            cacb2_reg  <= cacb_reg;
            casb2_reg  <= casb_reg;
            shca2_reg  <= shca_reg;
            chsb2_reg  <= chsb_reg;
            chcb2_reg  <= chcb_reg;
            shcb2_reg  <= shcb_reg;
        end
    end

    // sums and rounding to q1.14
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            out_reg.row0_col0 <= to_q14(SW'(chca2_reg));
            out_reg.row0_col1 <= to_q14(SW'(shsb2_reg) - SW'(chsacb_reg));
            out_reg.row0_col2 <= to_q14(SW'(chsasb_reg) + SW'(shcb2_reg));
            out_reg.row1_col0 <= to_q14(SW'(sa2_reg));
            out_reg.row1_col1 <= to_q14(SW'(cacb2_reg));
            out_reg.row1_col2 <= to_q14(-SW'(casb2_reg));
            out_reg.row2_col0 <= to_q14(-SW'(shca2_reg));
            out_reg.row2_col1 <= to_q14(SW'(shsacb_reg) + SW'(chsb2_reg));
            out_reg.row2_col2 <= to_q14(SW'(chcb2_reg) - SW'(shsasb_reg));
        end
    end

    assign m_out = out_reg;

endmodule

// File: hdl/euler_angles_to_rotation_matrix_core.sv
// throughput: one transaction per cycle while the output is not stalled by m_ready,
// set by the unrolled cordic and product pipeline
// a stalled output lets bubbles in the pipeline collapse before input is held off
// reset: aresetn synchronous active low, clears all valid bits only
module euler_angles_to_rotation_matrix_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  erm_pkg::erm_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output erm_pkg::erm_out_t m_data
);
    import erm_pkg::*;

    logic [PIPE_DEPTH-1:0] vld_reg, vld_next, en;
    logic signed [TW-1:0]  sb, cb, sa, ca, sh, ch;

    always_comb begin
        en[PIPE_DEPTH-1] = !vld_reg[PIPE_DEPTH-1] || m_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = en[0] ? s_valid : vld_reg[0];
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    erm_sincos u_bank (
        .aclk    (aclk),
        .en      (en[SC_DEPTH-1:0]),
        .angle   (s_data.bank_angle),
        .sin_q30 (sb),
        .cos_q30 (cb)
    );

    erm_sincos u_attitude (
        .aclk    (aclk),
        .en      (en[SC_DEPTH-1:0]),
        .angle   (s_data.attitude_angle),
        .sin_q30 (sa),
        .cos_q30 (ca)
    );

    erm_sincos u_heading (
        .aclk    (aclk),
        .en      (en[SC_DEPTH-1:0]),
        .angle   (s_data.heading_angle),
        .sin_q30 (sh),
        .cos_q30 (ch)
    );

    erm_matrix u_matrix (
        .aclk  (aclk),
        .en    (en[PIPE_DEPTH-1:SC_DEPTH]),
        .sb    (sb),
        .cb    (cb),
        .sa    (sa),
        .ca    (ca),
        .sh    (sh),
        .ch    (ch),
        .m_out (m_data)
    );

    assign s_ready = en[0];
    assign m_valid = vld_reg[PIPE_DEPTH-1];

endmodule

// File: hdl/erm_checker.sv
`include "euler_angles_to_rotation_matrix_core_assert.svh"

module erm_props (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input erm_pkg::erm_out_t m_data
);
    import erm_pkg::*;

    `ERM_ASSERT(a_m_valid_hold, m_valid && !m_ready |=> m_valid, "result transaction dropped")
    `ERM_ASSERT(a_m_data_hold, m_valid && !m_ready |=> $stable(m_data), "stalled result changed")
    `ERM_ASSERT_ALWAYS(a_reset_empty, $past(!aresetn) |-> !m_valid, "valid result after reset")
    `ERM_ASSERT(a_ready_when_drained, !m_valid || m_ready |-> s_ready, "input held off with free output")

endmodule

bind euler_angles_to_rotation_matrix_core erm_props u_erm_props (.*);
